// ===== src/wheel_sync_pi_correction_assert.svh =====
// Assertion macros shared by the wheel synchronisation PI correction modules.
`ifndef WHEEL_SYNC_PI_CORRECTION_ASSERT_SVH
`define WHEEL_SYNC_PI_CORRECTION_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define WSPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wspc: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wspc: next-cycle check failed");

`else

`define WSPC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/wspc_pkg.sv =====
// Types and constants shared by the wheel synchronisation PI correction modules.
package wspc_pkg;

  // Field widths
  localparam int unsigned ERR_W  = 16;
  localparam int unsigned DUTY_W = 16;
  localparam int unsigned RUN_W  = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 2;

  // Shared multiplier: signed 33 x signed 18
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Limited integral for the duty product, and correction accumulator
  localparam int unsigned ICLIP_W = 34;
  localparam int unsigned ILO_W   = 17;
  localparam int unsigned ACC_W   = 66;
  localparam int unsigned FRAC_W  = 24;

  // 0.35 as an unsigned Q0.16 value
  localparam logic signed [MUL_A_W-1:0] K_035 = 33'sd22938;

  // Register reset values
  localparam logic [CFG_W-1:0] PWM_PERIOD_RST = 16'd1199;
  localparam logic [CFG_W-1:0] PROP_GAIN_RST  = 16'd256;
  localparam logic [CFG_W-1:0] INTEG_GAIN_RST = 16'd0;
  localparam logic [CFG_W-1:0] MAX_DUTY_RST   = 16'd1199;

  typedef enum logic [IDX_W-1:0] {
    CFG_PWM_PERIOD = 2'd0,
    CFG_PROP_GAIN  = 2'd1,
    CFG_INTEG_GAIN = 2'd2,
    CFG_MAX_DUTY   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] pwm_period;
    logic [CFG_W-1:0] prop_gain;
    logic [CFG_W-1:0] integ_gain;
    logic [CFG_W-1:0] max_duty;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RUN,
    ST_INTEG,
    ST_GAIN,
    ST_ILO,
    ST_IHI,
    ST_SUM,
    ST_LEFT,
    ST_RIGHT,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MUL_RUN_DIFF,
    MUL_PROP_ERR,
    MUL_GAIN_K,
    MUL_G_LO,
    MUL_G_HI
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    logic     upd_integ;
    logic     acc_init;
    logic     acc_add_lo;
    logic     acc_add_hi;
    logic     latch_g;
    logic     calc_left;
    logic     calc_right;
    logic     load_out;
  } cmd_t;

endpackage

// ===== src/wspc_cfg.sv =====
// Configuration register bank of the wheel synchronisation PI correction.
module wspc_cfg
  import wspc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [CFG_W-1:0] data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index of a write
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_PWM_PERIOD: cfg_d.pwm_period = data_i;
        CFG_PROP_GAIN:  cfg_d.prop_gain  = data_i;
        CFG_INTEG_GAIN: cfg_d.integ_gain = data_i;
        CFG_MAX_DUTY:   cfg_d.max_duty   = data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period <= PWM_PERIOD_RST;
      cfg_q.prop_gain  <= PROP_GAIN_RST;
      cfg_q.integ_gain <= INTEG_GAIN_RST;
      cfg_q.max_duty   <= MAX_DUTY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/wspc_ctrl.sv =====
// Sequencer that steps the PI correction datapath through one control tick.
`include "wheel_sync_pi_correction_assert.svh"

module wspc_ctrl
  import wspc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic tick_due_i,
  input  logic out_busy_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_RUN_DIFF;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (tick_due_i) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd_o.mul_sel = MUL_RUN_DIFF;
        state_d = ST_INTEG;
      end
      ST_INTEG: begin
        cmd_o.upd_integ = 1'b1;
        cmd_o.mul_sel   = MUL_PROP_ERR;
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.acc_init = 1'b1;
        cmd_o.mul_sel  = MUL_GAIN_K;
        state_d = ST_ILO;
      end
      ST_ILO: begin
        cmd_o.latch_g = 1'b1;
        cmd_o.mul_sel = MUL_G_LO;
        state_d = ST_IHI;
      end
      ST_IHI: begin
        cmd_o.acc_add_lo = 1'b1;
        cmd_o.mul_sel    = MUL_G_HI;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.acc_add_hi = 1'b1;
        state_d = ST_LEFT;
      end
      ST_LEFT: begin
        cmd_o.calc_left = 1'b1;
        state_d = ST_RIGHT;
      end
      ST_RIGHT: begin
        cmd_o.calc_right = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // An accepted word with a tick due starts the sequence
  `WSPC_ASSERT_NEXT(a_tick_starts, clk_i, rst_ni, in_valid_i && in_ready_o && tick_due_i, state_q == ST_RUN)
  // A word without a tick due leaves the sequencer idle
  `WSPC_ASSERT_NEXT(a_no_tick_idle, clk_i, rst_ni, in_valid_i && in_ready_o && !tick_due_i, state_q == ST_IDLE)
  // A result is never loaded over one that is still waiting
  `WSPC_ASSERT_IMPL(a_load_free, clk_i, rst_ni, cmd_o.load_out, !out_busy_i)

endmodule

// ===== src/wspc_datapath.sv =====
// Datapath: integral and run count update, shared multiplier, duty clamp, output register.
`include "wheel_sync_pi_correction_assert.svh"

module wspc_datapath
  import wspc_pkg::*;
#(
  parameter int unsigned INTEGRAL_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  cmd_t                  cmd_i,
  input  logic [2*ERR_W-1:0]    in_data_i,
  input  logic                  out_ready_i,
  output logic                  out_busy_o,
  output logic                  out_valid_o,
  output logic [2*DUTY_W-1:0]   out_data_o
);

  localparam int unsigned IW    = INTEGRAL_WIDTH;
  localparam int unsigned SUM_W = ((IW > 33) ? IW : 33) + 1;
  localparam int unsigned EXT_W = (IW > ICLIP_W) ? IW : ICLIP_W;

  localparam logic signed [SUM_W-1:0] I_MAX = (SUM_W'(1) <<< (IW - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] I_MIN = ~I_MAX;
  localparam logic signed [EXT_W-1:0] CLIP_POS = EXT_W'(34'sd4294967296);
  localparam logic signed [EXT_W-1:0] CLIP_NEG = -CLIP_POS;
  localparam logic signed [ACC_W-1:0] ONE_Q24 = ACC_W'(1) <<< FRAC_W;

  logic signed [ERR_W-1:0]   now_q, before_q;
  logic signed [IW-1:0]      integ_q, integ_d;
  logic [RUN_W-1:0]          run_q, run_d;
  logic signed [MUL_P_W-1:0] prod_q;
  logic signed [MUL_A_W-1:0] g_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [DUTY_W-1:0]         left_q, right_q;
  logic                      out_valid_q, out_valid_d;
  logic [2*DUTY_W-1:0]       out_data_q;

  logic [ERR_W:0]            abs_now, abs_before;
  logic                      grow;
  logic signed [ERR_W:0]     diff;
  logic signed [SUM_W-1:0]   integ_ext, integ_sum;
  logic signed [EXT_W-1:0]   integ_x;
  logic signed [ICLIP_W-1:0] iclip;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [ACC_W-1:0]   p_ext, half, top, duty_sum;
  logic [DUTY_W-1:0]         duty;

  // Input word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      now_q    <= in_data_i[ERR_W-1:0];
      before_q <= in_data_i[2*ERR_W-1:ERR_W];
    end
  end

  // Magnitude comparison and error change
  assign abs_now    = now_q[ERR_W-1] ? ((ERR_W+1)'(0) - {1'b1, now_q})
                                     : {1'b0, now_q};
  assign abs_before = before_q[ERR_W-1] ? ((ERR_W+1)'(0) - {1'b1, before_q})
                                        : {1'b0, before_q};
  assign grow = (abs_now >= abs_before);
  assign diff = (ERR_W+1)'(before_q) - (ERR_W+1)'(now_q);

  // Integral update with saturation to the signed integral range
  assign integ_ext = SUM_W'(integ_q);
  always_comb begin
    if (grow) begin
      integ_sum = integ_ext + SUM_W'(now_q);
    end else begin
      integ_sum = integ_ext - SUM_W'($signed(prod_q[MUL_A_W-1:0]));
    end
    if (integ_sum > I_MAX) begin
      integ_d = I_MAX[IW-1:0];
    end else if (integ_sum < I_MIN) begin
      integ_d = I_MIN[IW-1:0];
    end else begin
      integ_d = integ_sum[IW-1:0];
    end
    if (!grow) begin
      run_d = '0;
    end else if (run_q == {RUN_W{1'b1}}) begin
      run_d = run_q;
    end else begin
      run_d = run_q + RUN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      run_q   <= '0;
    end else if (cmd_i.upd_integ) begin
      integ_q <= integ_d;
      run_q   <= run_d;
    end
  end

  // Integral limited for the duty product
  assign integ_x = EXT_W'(integ_q);
  always_comb begin
    if (integ_x > CLIP_POS) begin
      iclip = CLIP_POS[ICLIP_W-1:0];
    end else if (integ_x < CLIP_NEG) begin
      iclip = CLIP_NEG[ICLIP_W-1:0];
    end else begin
      iclip = integ_x[ICLIP_W-1:0];
    end
  end

  // Shared multiplier operand selection
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_RUN_DIFF: begin
        mul_a = MUL_A_W'(diff);
        mul_b = {2'b00, run_q};
      end
      MUL_PROP_ERR: begin
        mul_a = MUL_A_W'(now_q);
        mul_b = {2'b00, cfg_i.prop_gain};
      end
      MUL_GAIN_K: begin
        mul_a = K_035;
        mul_b = {2'b00, cfg_i.integ_gain};
      end
      MUL_G_LO: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = {1'b0, iclip[ILO_W-1:0]};
      end
      MUL_G_HI: begin
        mul_a = g_q;
        mul_b = {iclip[ICLIP_W-1], iclip[ICLIP_W-1:ILO_W]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (cmd_i.latch_g) begin
      g_q <= prod_q[MUL_A_W-1:0];
    end
  end

  // Correction accumulator: P term, then the two halves of the I term
  assign p_ext = ACC_W'(prod_q);
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_init) begin
      acc_d = p_ext <<< 15;
    end else if (cmd_i.acc_add_lo) begin
      acc_d = acc_q + p_ext;
    end else if (cmd_i.acc_add_hi) begin
      acc_d = acc_q + (p_ext <<< ILO_W);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Duty formation and clamp, one wheel per cycle
  assign half = ACC_W'({cfg_i.pwm_period, 23'b0});
  assign top  = ACC_W'({cfg_i.max_duty, {FRAC_W{1'b0}}});
  assign duty_sum = cmd_i.calc_right ? (half + acc_q) : (half - acc_q);

  always_comb begin
    if (duty_sum > top) begin
      duty = (cfg_i.max_duty == '0) ? DUTY_W'(1) : cfg_i.max_duty;
    end else if (duty_sum < ONE_Q24) begin
      duty = DUTY_W'(1);
    end else begin
      duty = duty_sum[FRAC_W+DUTY_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_left) begin
      left_q <= duty;
    end
    if (cmd_i.calc_right) begin
      right_q <= duty;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {right_q, left_q};
    end
  end

  assign out_busy_o  = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A shrinking error clears the run count
  `WSPC_ASSERT_NEXT(a_run_cleared, clk_i, rst_ni, cmd_i.upd_integ && !grow, run_q == '0)
  // Offered duties never fall below one
  `WSPC_ASSERT_IMPL(a_duty_nonzero, clk_i, rst_ni, out_valid_q, (out_data_q[DUTY_W-1:0] != '0) && (out_data_q[2*DUTY_W-1:DUTY_W] != '0))
  // A loaded result is offered in the next cycle
  `WSPC_ASSERT_NEXT(a_load_offers, clk_i, rst_ni, cmd_i.load_out, out_valid_q)

endmodule

// ===== src/wheel_sync_pi_correction.sv =====
// Top level of the wheel synchronisation PI correction for a differential drive.

// Each input word carries a tick flag and the current and previous encoder
// differences. A word without a tick due is taken and gives no result. A word
// with a tick due updates the error integral and run count and yields one word
// holding both PWM compare values. The single shared 33 x 18 bit multiplier
// forms, in turn, the run correction, the P term, the gain product and the two
// halves of the I term. The sequencer then adds the last partial product,
// clamps the duty of each wheel in turn and loads the output register; only
// then does it return to idle and take the next word. The result sits in an
// output register, so the next input word is accepted while it waits to be
// taken. The sequencer only stalls before loading a new result while the
// previous one is still waiting. Configuration writes take effect on the next
// clock edge.
module wheel_sync_pi_correction
  import wspc_pkg::*;
#(
  parameter int unsigned INTEGRAL_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*ERR_W-1:0]  s_axis_tdata,   // [15:0] error_now, [31:16] error_before
  input  logic                s_axis_tuser,   // [0] tick_due
  // Output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [2*DUTY_W-1:0] m_axis_tdata    // [15:0] duty_left, [31:16] duty_right
);

  cfg_t cfg;
  cmd_t cmd;
  logic out_busy;

  wspc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  wspc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .tick_due_i (s_axis_tuser),
    .out_busy_i (out_busy),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  wspc_datapath #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_busy_o  (out_busy),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== tb/tb_wheel_sync_pi_correction.sv =====
// Self-checking testbench for the wheel synchronisation PI correction block.
module tb_wheel_sync_pi_correction;
  import wspc_pkg::*;

  localparam int unsigned INTEGRAL_WIDTH = 32;

  // Fixed-point constants of the correction arithmetic.
  localparam longint FRAC_035    = 64'sd22938;
  localparam longint ONE_Q24     = 64'sd1 <<< 24;
  localparam longint IPROD_LIMIT = 64'sd1 <<< 32;
  localparam longint INTEG_HI    = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint INTEG_LO    = -INTEG_HI - 1;
  localparam longint RUN_MAX     = 64'sd65535;

  // Run control.
  localparam int SETTLE_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int MAX_FAULT_LINES  = 60;
  localparam int RAND_PHASES      = 6;
  localparam int TICKS_PER_PHASE  = 70;
  localparam int SAT_TICK_CAP     = 24;
  localparam int NEG_TICK_CAP     = 16;
  localparam int NUM_DIRECTED     = 29;

  typedef struct packed {
    logic               tick;
    logic signed [15:0] err_now;
    logic signed [15:0] err_prior;
  } tick_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left;
    logic [DUTY_W-1:0] right;
  } duty_pair_t;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [CFG_W-1:0]  value;
    tick_word_t        word;
    logic              typed;
    duty_pair_t        lit;
  } plan_row_t;

  // Signals towards and from the block.
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [IDX_W-1:0]    cfg_idx_i     = '0;
  logic [CFG_W-1:0]    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [2*ERR_W-1:0]  s_axis_tdata  = '0;   // [15:0] error_now, [31:16] error_before
  logic                s_axis_tuser  = 1'b0; // [0] tick_due
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [2*DUTY_W-1:0] m_axis_tdata;         // [15:0] duty_left, [31:16] duty_right

  // Shadow copy of the registers and of the controller state.
  logic [CFG_W-1:0] cfg_period = PWM_PERIOD_RST;
  logic [CFG_W-1:0] cfg_prop   = PROP_GAIN_RST;
  logic [CFG_W-1:0] cfg_integ  = INTEG_GAIN_RST;
  logic [CFG_W-1:0] cfg_max    = MAX_DUTY_RST;
  longint           integ_acc  = 0;
  longint           run_len    = 0;

  duty_pair_t pending_duties[$];
  int         fault_count = 0;
  int         idle_cycles = 0;
  int         hold_left   = 0;
  bit         calm        = 1'b0;

  // Directed stimulus: register writes and words, with hand-worked duties where obvious.
  plan_row_t directed_plan [0:NUM_DIRECTED-1] = '{
    // Reset settings, zero error: both duties sit at half the period.
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sd0, 16'sd0}, 1'b1, '{16'd599, 16'd599}},
    // No tick due: the word is dropped.
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b0, 16'sd1234, -16'sd5}, 1'b1, '{16'd0, 16'd0}},
    // Extreme errors drive the duties into both clamps.
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sh7FFF, 16'sd0}, 1'b1, '{16'd1, 16'd1199}},
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sh8000, 16'sd0}, 1'b1, '{16'd1199, 16'd1}},
    // Shrinking error with a run of three, then with the run cleared.
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sd0, 16'sh8000}, 1'b1, '{16'd599, 16'd599}},
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sd5, -16'sd7}, 1'b1, '{16'd597, 16'd602}},
    // Equal magnitudes count as growth.
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, -16'sd3, 16'sd3}, 1'b1, '{16'd601, 16'd598}},
    '{ROW_REG, CFG_INTEG_GAIN, 16'd300, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sd100, 16'sd50}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, -16'sd40, -16'sd90}, 1'b0, '{16'd0, 16'd0}},
    // An upper clamp of zero falls back to the lower clamp.
    '{ROW_REG, CFG_MAX_DUTY, 16'd0, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sd0, 16'sd0}, 1'b1, '{16'd1, 16'd1}},
    // Zero period: the midpoint is zero.
    '{ROW_REG, CFG_MAX_DUTY, 16'hFFFF, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_REG, CFG_PWM_PERIOD, 16'd0, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sd7, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    // Every register at its top value.
    '{ROW_REG, CFG_PWM_PERIOD, 16'hFFFF, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_REG, CFG_PROP_GAIN, 16'hFFFF, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_REG, CFG_INTEG_GAIN, 16'hFFFF, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sh7FFF, 16'sh8000}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sh8000, 16'sh7FFF}, 1'b0, '{16'd0, 16'd0}},
    // Smallest period and clamp: every duty is one.
    '{ROW_REG, CFG_PWM_PERIOD, 16'd1, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_REG, CFG_MAX_DUTY, 16'd1, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sd123, 16'sd0}, 1'b1, '{16'd1, 16'd1}},
    // Zero gains: the duties ignore the error completely.
    '{ROW_REG, CFG_PROP_GAIN, 16'd0, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_REG, CFG_INTEG_GAIN, 16'd0, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_REG, CFG_PWM_PERIOD, 16'd1199, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_REG, CFG_MAX_DUTY, 16'd1199, '{1'b0, 16'sd0, 16'sd0}, 1'b0, '{16'd0, 16'd0}},
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b1, 16'sh8000, 16'sh8000}, 1'b1, '{16'd599, 16'd599}},
    '{ROW_WORD, CFG_PWM_PERIOD, 16'd0, '{1'b0, 16'sh8000, 16'sh7FFF}, 1'b1, '{16'd0, 16'd0}}
  };

  wheel_sync_pi_correction #(
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a period of ten units.
  always #5 clk_i = ~clk_i;

  // Gap length: mostly none or short, now and then long; none in calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic longint sat_integral(input longint v);
    if (v > INTEG_HI) begin
      return INTEG_HI;
    end else if (v < INTEG_LO) begin
      return INTEG_LO;
    end
    return v;
  endfunction

  // Turns a sum in units of 2^-24 into a compare value within 1..max_duty, or one when max_duty is zero.
  function automatic logic [DUTY_W-1:0] clamp_duty(input longint s);
    longint d;
    if (s > (longint'(cfg_max) <<< 24)) begin
      d = longint'(cfg_max);
    end else if (s < ONE_Q24) begin
      d = 1;
    end else begin
      d = s >>> 24;
    end
    if (d < 1) begin
      d = 1;
    end
    return d[DUTY_W-1:0];
  endfunction

  // Advances the integral and run count for one word and forms both duties.
  task automatic pi_correct(input tick_word_t w, output bit has_duty, output duty_pair_t duties);
    longint e_now, e_prior, mag_now, mag_prior, iclip, half, corr;
    has_duty = w.tick;
    duties   = '0;
    if (w.tick) begin
      e_now     = longint'(w.err_now);
      e_prior   = longint'(w.err_prior);
      mag_now   = (e_now < 0) ? -e_now : e_now;
      mag_prior = (e_prior < 0) ? -e_prior : e_prior;
      if (mag_now >= mag_prior) begin
        integ_acc = sat_integral(integ_acc + e_now);
        if (run_len < RUN_MAX) begin
          run_len = run_len + 1;
        end
      end else begin
        integ_acc = sat_integral(integ_acc - run_len * (e_prior - e_now));
        run_len   = 0;
      end
      // The integral only enters the product within plus and minus 2^32.
      iclip = integ_acc;
      if (iclip > IPROD_LIMIT) begin
        iclip = IPROD_LIMIT;
      end else if (iclip < -IPROD_LIMIT) begin
        iclip = -IPROD_LIMIT;
      end
      half = longint'(cfg_period) <<< 23;
      corr = longint'(cfg_prop) * e_now * 32768 + longint'(cfg_integ) * FRAC_035 * iclip;
      duties.left  = clamp_duty(half - corr);
      duties.right = clamp_duty(half + corr);
    end
  endtask

  task automatic report_fault(input string msg);
    if (fault_count < MAX_FAULT_LINES) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    fault_count++;
  endtask

  // Offers one word after a random gap and files its duties once it is taken.
  task automatic send_encoder_word(input tick_word_t w, input bit typed, input duty_pair_t lit);
    int         gap;
    bit         has_duty;
    duty_pair_t duties;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.tick;
    s_axis_tdata  <= {w.err_prior, w.err_now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pi_correct(w, has_duty, duties);
    if (has_duty) begin
      pending_duties.push_back(typed ? lit : duties);
    end
  endtask

  // Waits until every expected word has come and the sequencer has had time to finish.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PWM_PERIOD: cfg_period = value;
      CFG_PROP_GAIN:  cfg_prop   = value;
      CFG_INTEG_GAIN: cfg_integ  = value;
      CFG_MAX_DUTY:   cfg_max    = value;
      default: ;
    endcase
  endtask

  // Output side back-pressure: random stalls, none started while calm.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Each result word is compared with the oldest expected pair of duties.
  always @(posedge clk_i) begin : check_results
    duty_pair_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_duties.size() == 0) begin
        report_fault($sformatf("result %h with nothing expected", m_axis_tdata));
      end else begin
        want = pending_duties.pop_front();
        if (m_axis_tdata[DUTY_W-1:0] !== want.left) begin
          report_fault($sformatf("duty_left %0d, expected %0d",
                                 m_axis_tdata[DUTY_W-1:0], want.left));
        end
        if (m_axis_tdata[2*DUTY_W-1:DUTY_W] !== want.right) begin
          report_fault($sformatf("duty_right %0d, expected %0d",
                                 m_axis_tdata[2*DUTY_W-1:DUTY_W], want.right));
        end
      end
    end
  end

  // Watchdog: ends the run when nothing is taken on any port for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no word moved for %0d cycles", $time, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int         phase, ticks, k, r, b, n, mag, last_now;
    logic [15:0] p, m;
    tick_word_t w;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part.
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_REG) begin
        write_reg(directed_plan[i].idx, directed_plan[i].value);
      end else begin
        send_encoder_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].lit);
      end
    end

    // Random part: a fresh setting per phase, every third phase without gaps.
    last_now = 0;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       p = 16'd1;
        1:       p = 16'hFFFF;
        2:       p = 16'($urandom_range(0, 65535));
        default: p = 16'($urandom_range(200, 4000));
      endcase
      case ($urandom_range(0, 5))
        0:       m = 16'd1;
        1:       m = 16'hFFFF;
        2:       m = 16'($urandom_range(0, 65535));
        default: m = 16'((p > 8) ? p - $urandom_range(0, p / 8) : p);
      endcase
      write_reg(CFG_PWM_PERIOD, p);
      write_reg(CFG_MAX_DUTY, m);
      case ($urandom_range(0, 5))
        0:       p = 16'd0;
        1:       p = 16'hFFFF;
        2:       p = 16'($urandom_range(0, 65535));
        default: p = 16'($urandom_range(0, 1024));
      endcase
      write_reg(CFG_PROP_GAIN, p);
      case ($urandom_range(0, 5))
        0:       p = 16'd0;
        1:       p = 16'hFFFF;
        2:       p = 16'($urandom_range(0, 65535));
        default: p = 16'($urandom_range(0, 32));
      endcase
      write_reg(CFG_INTEG_GAIN, p);
      calm = (phase % 3 == 1);

      ticks = 0;
      while (ticks < TICKS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        w.tick = 1'b1;
        if (r < 12) begin
          // Dropped word with arbitrary content.
          w.tick      = 1'b0;
          w.err_now   = 16'($urandom_range(0, 65535));
          w.err_prior = 16'($urandom_range(0, 65535));
        end else if (r < 70) begin
          // Consecutive ticks: the previous difference either decays or drifts.
          b   = last_now;
          mag = (b < 0) ? -b : b;
          if ($urandom_range(0, 1) == 0) begin
            n = b - ((b < 0) ? -1 : 1) * $urandom_range(0, mag);
          end else begin
            n = b + $urandom_range(0, 600) - 300;
          end
          n = (n > 32767) ? 32767 : ((n < -32768) ? -32768 : n);
          w.err_prior = 16'(b);
          w.err_now   = 16'(n);
          last_now    = n;
        end else if (r < 85) begin
          w.err_now   = 16'($urandom_range(0, 128) - 64);
          w.err_prior = 16'($urandom_range(0, 128) - 64);
        end else begin
          // Broken sequence: unrelated full-range differences.
          w.err_now   = 16'($urandom_range(0, 65535));
          w.err_prior = 16'($urandom_range(0, 65535));
          last_now    = int'(w.err_now);
        end
        send_encoder_word(w, 1'b0, '0);
        if (w.tick) begin
          ticks++;
        end
      end
    end

    // Strong errors: a run of large growths lifts the integral and the run count,
    // then one strong shrink and a few negative growths pull the integral back down.
    calm = 1'b1;
    write_reg(CFG_PWM_PERIOD, 16'd1199);
    write_reg(CFG_PROP_GAIN, 16'd256);
    write_reg(CFG_INTEG_GAIN, 16'd1);
    write_reg(CFG_MAX_DUTY, 16'd1199);
    w = '{1'b1, 16'sh7FFF, 16'sd0};
    for (k = 0; k < SAT_TICK_CAP && !(integ_acc == INTEG_HI && run_len == RUN_MAX); k++) begin
      send_encoder_word(w, 1'b0, '0);
    end
    send_encoder_word('{1'b1, -16'sd32766, 16'sh7FFF}, 1'b0, '0);
    w = '{1'b1, 16'sh8000, 16'sd0};
    for (k = 0; k < NEG_TICK_CAP && integ_acc != INTEG_LO; k++) begin
      send_encoder_word(w, 1'b0, '0);
    end
    send_encoder_word('{1'b1, 16'sd0, 16'sh8000}, 1'b0, '0);

    // Drain; a result that never comes is caught by the watchdog.
    wait_idle();
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
